>>> rtl/aeo_pkg.sv
// aeo_pkg: shared constants for the absolute encoder odometer
// field widths, register indexes and command codes; no dependencies
`timescale 1ns / 1ps

package aeo_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 12;

  localparam int unsigned RAW_W    = 12;
  localparam int unsigned ACCUM_W  = 32;
  localparam int unsigned PERIM_W  = 20;
  localparam int unsigned DBAND_W  = 12;
  localparam int unsigned DIST_W   = 52;
  localparam int unsigned TURNS_W  = 20;
  localparam int unsigned PROD_W   = ACCUM_W + PERIM_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIMETER = 2'd1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_RESYNC = 1'b1;

endpackage

>>> rtl/absolute_encoder_odometer_core.sv
// absolute_encoder_odometer_core: multi-turn unwrap of absolute angle samples
// depends on aeo_pkg
`timescale 1ns / 1ps

// usage:
//   input channel (in_valid_i / in_ready_o) carries cmd_i and raw_angle_i;
//   cmd resync clears the count and takes the sample as reference, cmd sample
//   adds the wrapped, deadbanded difference to the saturating count once synced.
//   output channel (out_valid_o / out_ready_i) returns one transaction per
//   input transaction: angle, count, distance, whole turns, saturation flag.
//   config channel (cfg_valid_i / cfg_ready_o) writes deadband (index 0) and
//   wheel perimeter (index 1); it is always ready, other indexes are ignored.
// timing:
//   one transaction per cycle while the output is not stalled; the count update,
//   32x21 multiply and truncating shift each sit behind a register. the count
//   state updates at accept, so samples chain directly.
// reset:
//   clears count, reference, sync flag, config registers and pipeline valids.
// stall:
//   a stalled output holds its transaction; the stages behind it fill, and
//   in_ready_o drops only once all three stages hold data.
module absolute_encoder_odometer_core #(
  parameter int unsigned ANGLE_BITS = aeo_pkg::ANGLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 cmd_i,
  input  logic [aeo_pkg::RAW_W-1:0]            raw_angle_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [aeo_pkg::RAW_W-1:0]            angle_now_o,
  output logic signed [aeo_pkg::ACCUM_W-1:0]   total_counts_o,
  output logic signed [aeo_pkg::DIST_W-1:0]    distance_um_o,
  output logic signed [aeo_pkg::TURNS_W-1:0]   turns_o,
  output logic                                 saturated_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [aeo_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [aeo_pkg::PERIM_W-1:0]          cfg_data_i
);

  localparam int unsigned AB    = ANGLE_BITS;
  localparam int unsigned DW    = AB + 2;
  localparam int unsigned CW    = (DW > aeo_pkg::DBAND_W + 1) ? DW : aeo_pkg::DBAND_W + 1;
  localparam int unsigned SW    = aeo_pkg::ACCUM_W + 1;
  localparam int unsigned PW    = aeo_pkg::PROD_W;
  localparam logic signed [DW-1:0] HALF = DW'(1) <<< (AB - 1);
  localparam logic signed [DW-1:0] TURN = DW'(1) <<< AB;

  // config registers
  logic [aeo_pkg::DBAND_W-1:0] dband_q;
  logic [aeo_pkg::PERIM_W-1:0] perim_q;

  // tracking state
  logic [AB-1:0]                     ref_q;
  logic signed [aeo_pkg::ACCUM_W-1:0] accum_q, accum_d;
  logic                              synced_q;

  // pipeline
  logic                               s1_v_q, s2_v_q, out_v_q;
  logic [aeo_pkg::RAW_W-1:0]          s1_angle_q, s2_angle_q, out_angle_q;
  logic signed [aeo_pkg::ACCUM_W-1:0] s1_accum_q, s2_accum_q, out_accum_q;
  logic                               s1_sat_q, s2_sat_q, out_sat_q;
  logic signed [PW-1:0]               s2_prod_q, prod_d;
  logic signed [aeo_pkg::TURNS_W-1:0] s2_turns_q, turns_d;
  logic signed [aeo_pkg::DIST_W-1:0]  out_dist_q, dist_d;

  logic in_acc, out_free, s2_move, s2_free, s1_move, s1_free;
  logic [AB-1:0]        sample;
  logic signed [DW-1:0] diff, delta;
  logic [CW-1:0]        mag;
  logic signed [SW-1:0] sum;
  logic                 sat_d;
  logic signed [SW-1:0] turn_biased;
  logic signed [PW-1:0] prod_biased;

  assign out_free = !out_v_q || out_ready_i;
  assign s2_move  = s2_v_q && out_free;
  assign s2_free  = !s2_v_q || s2_move;
  assign s1_move  = s1_v_q && s2_free;
  assign s1_free  = !s1_v_q || s1_move;
  assign in_ready_o = s1_free;
  assign in_acc     = in_valid_i && s1_free;
  assign cfg_ready_o = 1'b1;

  // count update
  always_comb begin
    sample = AB'(raw_angle_i);
    diff   = $signed(DW'(sample)) - $signed(DW'(ref_q));
    delta  = diff;
    if (diff < -HALF) begin
      delta = diff + TURN;
    end else if (diff > HALF) begin
      delta = diff - TURN;
    end
    mag = (delta < 0) ? CW'(-delta) : CW'(delta);
    if (mag < CW'(dband_q)) begin
      delta = '0;
    end
    sum     = SW'(accum_q) + SW'(delta);
    sat_d   = 1'b0;
    accum_d = accum_q;
    if (cmd_i == aeo_pkg::CMD_RESYNC) begin
      accum_d = '0;
    end else if (synced_q) begin
      if (!sum[SW-1] && sum[SW-2]) begin
        accum_d = {1'b0, {(aeo_pkg::ACCUM_W-1){1'b1}}};
        sat_d   = 1'b1;
      end else if (sum[SW-1] && !sum[SW-2]) begin
        accum_d = {1'b1, {(aeo_pkg::ACCUM_W-1){1'b0}}};
        sat_d   = 1'b1;
      end else begin
        accum_d = sum[aeo_pkg::ACCUM_W-1:0];
      end
    end
  end

  // multiply and truncating divides toward zero
  always_comb begin
    prod_d      = PW'(s1_accum_q) * $signed({1'b0, perim_q});
    turn_biased = SW'(s1_accum_q) + (s1_accum_q[aeo_pkg::ACCUM_W-1] ? SW'((1 << AB) - 1) : '0);
    turns_d     = aeo_pkg::TURNS_W'(turn_biased >>> AB);
    prod_biased = s2_prod_q + (s2_prod_q[PW-1] ? PW'((1 << AB) - 1) : '0);
    dist_d      = aeo_pkg::DIST_W'(prod_biased >>> AB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dband_q  <= '0;
      perim_q  <= '0;
      ref_q    <= '0;
      accum_q  <= '0;
      synced_q <= 1'b0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          aeo_pkg::REG_DEADBAND:  dband_q <= cfg_data_i[aeo_pkg::DBAND_W-1:0];
          aeo_pkg::REG_PERIMETER: perim_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        ref_q   <= sample;
        accum_q <= accum_d;
        if (cmd_i == aeo_pkg::CMD_RESYNC) begin
          synced_q <= 1'b1;
        end
      end
      if (s1_free) s1_v_q <= in_valid_i;
      if (s2_free) s2_v_q <= s1_v_q;
      if (out_free) out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_angle_q <= aeo_pkg::RAW_W'(sample);
      s1_accum_q <= accum_d;
      s1_sat_q   <= sat_d;
    end
    if (s1_move) begin
      s2_angle_q <= s1_angle_q;
      s2_accum_q <= s1_accum_q;
      s2_sat_q   <= s1_sat_q;
      s2_prod_q  <= prod_d;
      s2_turns_q <= turns_d;
    end
    if (s2_move) begin
      out_angle_q <= s2_angle_q;
      out_accum_q <= s2_accum_q;
      out_sat_q   <= s2_sat_q;
      out_dist_q  <= dist_d;
      turns_o     <= s2_turns_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign angle_now_o    = out_angle_q;
  assign total_counts_o = out_accum_q;
  assign distance_um_o  = out_dist_q;
  assign saturated_o    = out_sat_q;

  // checks
  a_ready_when_out_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> in_ready_o)
    else $error("input stalled with empty output stage");

  a_resync_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd_i == aeo_pkg::CMD_RESYNC) |=> (accum_q == '0 && synced_q))
    else $error("resync did not clear count");

  a_unsynced_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd_i == aeo_pkg::CMD_SAMPLE && !synced_q) |=> $stable(accum_q))
    else $error("count moved before first resync");

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s2_free) |=> (s1_v_q && $stable(s1_accum_q)))
    else $error("first stage lost data under stall");

endmodule

>>> dv/absolute_encoder_odometer_core_tb.sv
// absolute_encoder_odometer_core_tb: self-checking bench for the multi-turn odometer core
// predicts every result from its own model of the count, feeds directed and random samples
// depends on aeo_pkg and rtl/absolute_encoder_odometer_core.sv
`timescale 1ns / 1ps

module absolute_encoder_odometer_core_tb;

  localparam int unsigned ANG_B      = aeo_pkg::ANGLE_BITS_DEF;
  localparam longint      TURN       = longint'(1) << ANG_B;
  localparam longint      HALF       = longint'(1) << (ANG_B - 1);
  localparam longint      CNT_MAX    = 2147483647;
  localparam longint      CNT_MIN    = -CNT_MAX - 1;
  localparam int          WDOG_LIMIT = 4000;

  typedef struct packed {
    logic                      cmd;
    logic [aeo_pkg::RAW_W-1:0] angle;
  } odo_cmd_t;

  typedef struct packed {
    logic        [aeo_pkg::RAW_W-1:0]   angle;
    logic signed [aeo_pkg::ACCUM_W-1:0] total;
    logic signed [aeo_pkg::DIST_W-1:0]  dist_um;
    logic signed [aeo_pkg::TURNS_W-1:0] turns;
    logic                               sat;
  } odo_result_t;

  logic                                 clk_i       = 1'b0;
  logic                                 rst_ni      = 1'b0;
  logic                                 in_valid_i  = 1'b0;
  logic                                 in_ready_o;
  logic                                 cmd_i       = aeo_pkg::CMD_SAMPLE;
  logic [aeo_pkg::RAW_W-1:0]            raw_angle_i = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic [aeo_pkg::RAW_W-1:0]            angle_now_o;
  logic signed [aeo_pkg::ACCUM_W-1:0]   total_counts_o;
  logic signed [aeo_pkg::DIST_W-1:0]    distance_um_o;
  logic signed [aeo_pkg::TURNS_W-1:0]   turns_o;
  logic                                 saturated_o;
  logic                                 cfg_valid_i = 1'b0;
  logic                                 cfg_ready_o;
  logic [aeo_pkg::CFG_IDX_W-1:0]        cfg_index_i = '0;
  logic [aeo_pkg::PERIM_W-1:0]          cfg_data_i  = '0;

  odo_cmd_t    sample_q[$];
  odo_result_t odo_expect_q[$];

  // model state
  logic [aeo_pkg::DBAND_W-1:0] odo_deadband = '0;
  logic [aeo_pkg::PERIM_W-1:0] odo_perim    = '0;
  longint                      odo_ref      = 0;
  longint                      odo_count    = 0;
  bit                          odo_synced   = 1'b0;

  int                        src_idle_pct   = 0;
  int                        sink_stall_pct = 0;
  int                        err_cnt        = 0;
  int                        quiet_cycles   = 0;
  logic [aeo_pkg::RAW_W-1:0] last_angle     = '0;

  absolute_encoder_odometer_core u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic odo_result_t odo_advance(logic cmd, logic [aeo_pkg::RAW_W-1:0] raw);
    longint      sample;
    longint      delta;
    longint      mag;
    longint      sum;
    longint      dist_v;
    longint      tv;
    odo_result_t r;
    sample = longint'(raw) & (TURN - 1);
    r.sat  = 1'b0;
    if (cmd == aeo_pkg::CMD_RESYNC) begin
      odo_count  = 0;
      odo_synced = 1'b1;
    end else if (odo_synced) begin
      delta = sample - odo_ref;
      if (delta < -HALF) delta = delta + TURN;
      else if (delta > HALF) delta = delta - TURN;
      mag = (delta < 0) ? -delta : delta;
      if (mag < longint'(odo_deadband)) delta = 0;
      sum = odo_count + delta;
      if (sum > CNT_MAX) begin
        sum   = CNT_MAX;
        r.sat = 1'b1;
      end else if (sum < CNT_MIN) begin
        sum   = CNT_MIN;
        r.sat = 1'b1;
      end
      odo_count = sum;
    end
    odo_ref   = sample;
    dist_v    = (odo_count * longint'(odo_perim)) / TURN;
    tv        = odo_count / TURN;
    r.angle   = sample[aeo_pkg::RAW_W-1:0];
    r.total   = odo_count[aeo_pkg::ACCUM_W-1:0];
    r.dist_um = dist_v[aeo_pkg::DIST_W-1:0];
    r.turns   = tv[aeo_pkg::TURNS_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want_v,
                                      logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      err_cnt++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        odo_expect_q.push_back(odo_advance(cmd_i, raw_angle_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          odo_cmd_t nxt;
          nxt = sample_q.pop_front();
          in_valid_i  <= 1'b1;
          cmd_i       <= nxt.cmd;
          raw_angle_i <= nxt.angle;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (odo_expect_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result transaction, actual angle %0d count %0d",
                   $time, angle_now_o, total_counts_o);
        end else begin
          odo_result_t want;
          want = odo_expect_q.pop_front();
          check_field("angle_now", want.angle, angle_now_o);
          check_field("total_counts", want.total, total_counts_o);
          check_field("distance_um", want.dist_um, distance_um_o);
          check_field("turns", want.turns, turns_o);
          check_field("saturated", want.sat, saturated_o);
        end
      end
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_item(logic cmd, logic [aeo_pkg::RAW_W-1:0] angle);
    while (sample_q.size() >= 16) @(posedge clk_i);
    sample_q.push_back('{cmd, angle});
    last_angle = angle;
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid_i || odo_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [aeo_pkg::CFG_IDX_W-1:0] idx,
                           logic [aeo_pkg::PERIM_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == aeo_pkg::REG_DEADBAND) odo_deadband = data[aeo_pkg::DBAND_W-1:0];
    else if (idx == aeo_pkg::REG_PERIMETER) odo_perim = data;
  endtask

  initial begin
    int                          sel;
    int                          d;
    int                          w;
    logic [aeo_pkg::DBAND_W-1:0] db;
    logic [aeo_pkg::PERIM_W-1:0] pr;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // samples before the first resync, then wrap edges with no deadband
    push_item(aeo_pkg::CMD_SAMPLE, 12'd100);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd4095);
    push_item(aeo_pkg::CMD_RESYNC, 12'd0);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd2048);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd0);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd4095);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd0);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd2049);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd2);
    wait_idle();

    // unknown indexes are dropped
    cfg_write(2'd2, 20'hABCDE);
    cfg_write(2'd3, 20'h12345);
    cfg_write(aeo_pkg::REG_DEADBAND, 20'd16);
    cfg_write(aeo_pkg::REG_PERIMETER, '1);
    push_item(aeo_pkg::CMD_RESYNC, 12'd1000);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd1015);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd1031);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd1015);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd1000);
    push_item(aeo_pkg::CMD_RESYNC, 12'd0);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd2049);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd2);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd2051);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd4095);
    wait_idle();

    // upper data bits above the deadband width are dropped
    cfg_write(aeo_pkg::REG_DEADBAND, 20'hFF800);
    cfg_write(aeo_pkg::REG_PERIMETER, 20'd1);
    push_item(aeo_pkg::CMD_RESYNC, 12'd4095);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd2047);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd4094);
    push_item(aeo_pkg::CMD_SAMPLE, 12'd0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
        default: begin src_idle_pct = 32; sink_stall_pct = 32; end
      endcase
      case (p)
        0: begin db = '0; pr = '1; end
        1: begin db = 12'd2048; pr = '0; end
        default: begin
          db = ($urandom_range(3) == 0) ? aeo_pkg::DBAND_W'($urandom_range(2048))
                                        : aeo_pkg::DBAND_W'($urandom_range(40));
          pr = aeo_pkg::PERIM_W'($urandom);
        end
      endcase
      cfg_write(aeo_pkg::REG_DEADBAND, aeo_pkg::PERIM_W'(db));
      cfg_write(aeo_pkg::REG_PERIMETER, pr);
      push_item(aeo_pkg::CMD_RESYNC, aeo_pkg::RAW_W'($urandom));
      for (int n = 0; n < 225; n++) begin
        sel = $urandom_range(99);
        if (sel < 4) begin
          push_item(aeo_pkg::CMD_RESYNC, aeo_pkg::RAW_W'($urandom));
        end else if (sel < 14) begin
          push_item(aeo_pkg::CMD_SAMPLE, aeo_pkg::RAW_W'($urandom));
        end else begin
          if (sel < 54) w = (int'(db) + 3 > 2048) ? 2048 : int'(db) + 3;
          else if (sel < 64) w = 8;
          else w = 2048;
          d = int'($urandom_range(2 * w)) - w;
          if (sel >= 90) begin
            case ($urandom_range(5))
              0: d = 2048;
              1: d = 2047;
              2: d = -2047;
              3: d = 2049;
              4: d = int'(db);
              default: d = -int'(db);
            endcase
          end
          push_item(aeo_pkg::CMD_SAMPLE, aeo_pkg::RAW_W'(int'(last_angle) + d));
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && odo_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
